### src/gmc_pkg.sv
package gmc_pkg;

    localparam int MAX_DIVISIONS = 1024;
    localparam logic [10:0] MAX_DIV_W = 11'(MAX_DIVISIONS);

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CELLS_PER_ROW = 3'd0,
        CFG_ROW_COUNT     = 3'd1,
        CFG_ALONG_LEN     = 3'd2,
        CFG_ACROSS_LEN    = 3'd3,
        CFG_DIAG_LEN      = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_TRI    = 2'd0,
        KIND_EDGE   = 2'd1,
        KIND_REJECT = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        STEP_TRI0   = 3'd0,
        STEP_TRI1   = 3'd1,
        STEP_SKEW   = 3'd2,
        STEP_BOTTOM = 3'd3,
        STEP_RIGHT  = 3'd4,
        STEP_TOP    = 3'd5,
        STEP_LEFT   = 3'd6
    } t_step;

    typedef struct packed {
        logic [10:0] cells_per_row;
        logic [10:0] row_count;
        logic [31:0] along_row_length;
        logic [31:0] across_row_length;
        logic [31:0] diagonal_length;
    } t_cfg;

    typedef struct packed {
        logic [9:0] cell_row;
        logic [9:0] cell_col;
    } t_cell;

    typedef struct packed {
        logic [1:0]  record_kind;
        logic [21:0] record_index;
        logic [20:0] vert_a;
        logic [20:0] vert_b;
        logic [20:0] vert_c;
        logic [20:0] tri_first;
        logic [20:0] tri_second;
        logic        has_second;
        logic        on_boundary;
        logic [31:0] rest_length;
        logic        last;
    } t_record;

    typedef struct packed {
        logic        reject;
        logic        even;
        logic        row_zero;
        logic        col_zero;
        logic        last_row;
        logic        last_col;
        logic [20:0] lu;
        logic [20:0] ld;
        logic [20:0] t0;
        logic [21:0] top;
        logic [21:0] left;
        logic [21:0] bottom;
        logic [11:0] h2;
    } t_desc;

endpackage

### src/grid_mesh_cell_generator.sv
// grid cell triangulator, alternating diagonals
//
// input queue side: one word per cell (row, column), taken when push is high
// and full is low. result queue side: the oldest record sits on o_rec while
// empty is low and is taken when pop is high.
// configuration: i_cfg_we writes i_cfg_data into the register named by
// i_cfg_idx; write only while no cell is in flight.
// each cell gives 5 to 7 records (two triangles, skew, bottom, right, plus top
// on row 0 and left on column 0); a cell outside the grid gives one reject.
// throughput: one record per cycle from the record sequencer while the output
// word is empty or popped; cells follow back to back.
// from accept to the first record on o_rec a cell passes the registers of the
// multiply stage, index add stage, two-entry queue, sequencer and output word.
// when pop is held low the output word holds, the sequencer and queue fill,
// and then full rises; nothing is dropped.
// reset: pipeline, queue and output cleared; registers return to 1, 1,
// 65536, 65536, 92682.
module grid_mesh_cell_generator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [gmc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [gmc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                push,
    input  gmc_pkg::t_cell                      i_cell,
    output logic                                full,
    output logic                                empty,
    output gmc_pkg::t_record                    o_rec,
    input  logic                                pop
);
    import gmc_pkg::*;

    t_cfg  r_cfg;
    logic  f_valid;
    t_desc f_desc;
    logic  q_rdy;
    logic  q_valid;
    t_desc q_desc;
    logic  q_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cells_per_row     <= 11'd1;
            r_cfg.row_count         <= 11'd1;
            r_cfg.along_row_length  <= 32'd65536;
            r_cfg.across_row_length <= 32'd65536;
            r_cfg.diagonal_length   <= 32'd92682;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CELLS_PER_ROW: r_cfg.cells_per_row     <= i_cfg_data[10:0];
                CFG_ROW_COUNT:     r_cfg.row_count         <= i_cfg_data[10:0];
                CFG_ALONG_LEN:     r_cfg.along_row_length  <= i_cfg_data;
                CFG_ACROSS_LEN:    r_cfg.across_row_length <= i_cfg_data;
                CFG_DIAG_LEN:      r_cfg.diagonal_length   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    gmc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .push    (push),
        .i_cell  (i_cell),
        .full    (full),
        .o_valid (f_valid),
        .o_desc  (f_desc),
        .i_rdy   (q_rdy)
    );

    gmc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (f_valid),
        .i_desc  (f_desc),
        .o_rdy   (q_rdy),
        .o_valid (q_valid),
        .o_desc  (q_desc),
        .i_rd    (q_rd)
    );

    gmc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (q_valid),
        .i_desc  (q_desc),
        .o_rd    (q_rd),
        .empty   (empty),
        .o_rec   (o_rec),
        .pop     (pop)
    );

endmodule

### src/gmc_front.sv
module gmc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  gmc_pkg::t_cfg  i_cfg,
    input  logic           push,
    input  gmc_pkg::t_cell i_cell,
    output logic           full,
    output logic           o_valid,
    output gmc_pkg::t_desc o_desc,
    input  logic           i_rdy
);
    import gmc_pkg::*;

    logic [10:0] h;
    logic [10:0] w;
    logic [11:0] h_p1;
    logic [11:0] e;
    logic        s1_rdy;
    logic        s2_rdy;

    logic        r_v1;
    logic [9:0]  r_row;
    logic [9:0]  r_col;
    logic [10:0] r_h;
    logic [11:0] r_e;
    logic [21:0] r_p_lu;
    logic [21:0] r_p_t;
    logic [21:0] r_p_top;
    logic        r_reject;
    logic        r_even;
    logic        r_last_row;
    logic        r_last_col;

    logic        r_v2;
    t_desc       r_desc;
    t_desc       n_desc;

    logic [21:0] lu_sum;
    logic [21:0] t_sum;
    logic [21:0] top_sum;

    assign h    = (i_cfg.cells_per_row > MAX_DIV_W) ? MAX_DIV_W : i_cfg.cells_per_row;
    assign w    = (i_cfg.row_count > MAX_DIV_W) ? MAX_DIV_W : i_cfg.row_count;
    assign h_p1 = {1'b0, h} + 12'd1;
    assign e    = {h, 1'b0} + {1'b0, h} + 12'd1;

    assign s2_rdy  = !r_v2 || i_rdy;
    assign s1_rdy  = !r_v1 || s2_rdy;
    assign full    = !s1_rdy;
    assign o_valid = r_v2;
    assign o_desc  = r_desc;

    // multiply stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (s1_rdy) begin
            r_v1 <= push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_rdy) begin
            r_row      <= i_cell.cell_row;
            r_col      <= i_cell.cell_col;
            r_h        <= h;
            r_e        <= e;
            r_p_lu     <= 22'(i_cell.cell_row) * 22'(h_p1);
            r_p_t      <= 22'(i_cell.cell_row) * 22'(h);
            r_p_top    <= 22'(i_cell.cell_row) * 22'(e);
            r_reject   <= ({1'b0, i_cell.cell_row} >= w) || ({1'b0, i_cell.cell_col} >= h);
            r_even     <= ~(i_cell.cell_row[0] ^ i_cell.cell_col[0]);
            r_last_row <= ({1'b0, i_cell.cell_row} == (w - 11'd1));
            r_last_col <= ({1'b0, i_cell.cell_col} == (h - 11'd1));
        end
    end

    // index add stage
    always_comb begin
        lu_sum  = r_p_lu + 22'(r_col);
        t_sum   = r_p_t + 22'(r_col);
        top_sum = r_p_top + 22'(r_col);
        n_desc.reject   = r_reject;
        n_desc.even     = r_even;
        n_desc.row_zero = (r_row == 10'd0);
        n_desc.col_zero = (r_col == 10'd0);
        n_desc.last_row = r_last_row;
        n_desc.last_col = r_last_col;
        n_desc.lu       = lu_sum[20:0];
        n_desc.ld       = 21'(lu_sum + 22'(r_h) + 22'd1);
        n_desc.t0       = {t_sum[19:0], 1'b0};
        n_desc.top      = top_sum;
        n_desc.left     = r_p_top + 22'(r_h) + {11'd0, r_col, 1'b0};
        n_desc.bottom   = top_sum + 22'(r_e);
        n_desc.h2       = {r_h, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (s2_rdy) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_rdy) begin
            r_desc <= n_desc;
        end
    end

endmodule

### src/gmc_queue.sv
module gmc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  gmc_pkg::t_desc i_desc,
    output logic           o_rdy,
    output logic           o_valid,
    output gmc_pkg::t_desc o_desc,
    input  logic           i_rd
);
    import gmc_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    t_desc            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [PTR_W:0]   r_cnt;
    logic             do_wr;
    logic             do_rd;

    assign o_rdy   = (r_cnt != (PTR_W+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_desc  = r_mem[r_rp];
    assign do_wr   = i_wr && o_rdy;
    assign do_rd   = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wp <= (r_wp == PTR_W'(DEPTH-1)) ? '0 : r_wp + PTR_W'(1);
            end
            if (do_rd) begin
                r_rp <= (r_rp == PTR_W'(DEPTH-1)) ? '0 : r_rp + PTR_W'(1);
            end
            r_cnt <= r_cnt + (PTR_W+1)'(do_wr) - (PTR_W+1)'(do_rd);
        end
    end

endmodule

### src/gmc_back.sv
module gmc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  gmc_pkg::t_cfg    i_cfg,
    input  logic             i_valid,
    input  gmc_pkg::t_desc   i_desc,
    output logic             o_rd,
    output logic             empty,
    output gmc_pkg::t_record o_rec,
    input  logic             pop
);
    import gmc_pkg::*;

    logic    r_cv;
    t_desc   r_cur;
    t_step   r_step;
    t_step   n_step;
    logic    r_ov;
    t_record r_out;
    t_record rec;
    logic    final_rec;
    logic    adv;
    logic    load;

    logic [20:0] ru;
    logic [20:0] rd;
    logic [20:0] t1;
    logic [20:0] btri;

    assign adv   = r_cv && (!r_ov || pop);
    assign load  = !r_cv || (adv && final_rec);
    assign o_rd  = load && i_valid;
    assign empty = !r_ov;
    assign o_rec = r_out;

    assign final_rec = r_cur.reject
                    || (r_step == STEP_LEFT)
                    || (r_step == STEP_TOP && !r_cur.col_zero)
                    || (r_step == STEP_RIGHT && !r_cur.row_zero && !r_cur.col_zero);

    // next step
    always_comb begin
        unique case (r_step)
            STEP_TRI0:   n_step = STEP_TRI1;
            STEP_TRI1:   n_step = STEP_SKEW;
            STEP_SKEW:   n_step = STEP_BOTTOM;
            STEP_BOTTOM: n_step = STEP_RIGHT;
            STEP_RIGHT:  n_step = r_cur.row_zero ? STEP_TOP : STEP_LEFT;
            STEP_TOP:    n_step = STEP_LEFT;
            STEP_LEFT:   n_step = STEP_TRI0;
            default:     n_step = STEP_TRI0;
        endcase
    end

    // record for the current step
    always_comb begin
        ru   = r_cur.lu + 21'd1;
        rd   = r_cur.ld + 21'd1;
        t1   = {r_cur.t0[20:1], 1'b1};
        btri = r_cur.even ? r_cur.t0 : t1;
        rec  = '0;
        rec.last = final_rec;
        if (r_cur.reject) begin
            rec.record_kind = KIND_REJECT;
        end else begin
            unique case (r_step)
                STEP_TRI0: begin
                    rec.record_kind  = KIND_TRI;
                    rec.record_index = {1'b0, r_cur.t0};
                    rec.vert_a       = r_cur.lu;
                    rec.vert_b       = r_cur.ld;
                    rec.vert_c       = r_cur.even ? rd : ru;
                end
                STEP_TRI1: begin
                    rec.record_kind  = KIND_TRI;
                    rec.record_index = {1'b0, t1};
                    rec.vert_a       = r_cur.even ? r_cur.lu : r_cur.ld;
                    rec.vert_b       = rd;
                    rec.vert_c       = ru;
                end
                STEP_SKEW: begin
                    rec.record_kind  = KIND_EDGE;
                    rec.record_index = r_cur.left + 22'd1;
                    rec.vert_a       = r_cur.even ? r_cur.lu : ru;
                    rec.vert_b       = r_cur.even ? rd : r_cur.ld;
                    rec.tri_first    = r_cur.t0;
                    rec.tri_second   = t1;
                    rec.has_second   = 1'b1;
                    rec.rest_length  = i_cfg.diagonal_length;
                end
                STEP_BOTTOM: begin
                    rec.record_kind  = KIND_EDGE;
                    rec.record_index = r_cur.bottom;
                    rec.vert_a       = r_cur.ld;
                    rec.vert_b       = rd;
                    rec.tri_first    = btri;
                    rec.tri_second   = r_cur.last_row ? 21'd0 : btri + 21'(r_cur.h2);
                    rec.has_second   = !r_cur.last_row;
                    rec.on_boundary  = r_cur.last_row;
                    rec.rest_length  = i_cfg.along_row_length;
                end
                STEP_RIGHT: begin
                    rec.record_kind  = KIND_EDGE;
                    rec.record_index = r_cur.left + 22'd2;
                    rec.vert_a       = ru;
                    rec.vert_b       = rd;
                    rec.tri_first    = t1;
                    rec.tri_second   = r_cur.last_col ? 21'd0 : t1 + 21'd1;
                    rec.has_second   = !r_cur.last_col;
                    rec.on_boundary  = r_cur.last_col;
                    rec.rest_length  = i_cfg.across_row_length;
                end
                STEP_TOP: begin
                    rec.record_kind  = KIND_EDGE;
                    rec.record_index = r_cur.top;
                    rec.vert_a       = r_cur.lu;
                    rec.vert_b       = ru;
                    rec.tri_first    = r_cur.even ? t1 : r_cur.t0;
                    rec.on_boundary  = 1'b1;
                    rec.rest_length  = i_cfg.along_row_length;
                end
                STEP_LEFT: begin
                    rec.record_kind  = KIND_EDGE;
                    rec.record_index = r_cur.left;
                    rec.vert_a       = r_cur.lu;
                    rec.vert_b       = r_cur.ld;
                    rec.tri_first    = r_cur.t0;
                    rec.on_boundary  = 1'b1;
                    rec.rest_length  = i_cfg.across_row_length;
                end
                default: begin
                    rec.record_kind = KIND_REJECT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv   <= 1'b0;
            r_step <= STEP_TRI0;
            r_ov   <= 1'b0;
        end else begin
            if (load) begin
                r_cv   <= i_valid;
                r_step <= STEP_TRI0;
            end else if (adv) begin
                r_step <= n_step;
            end
            if (adv) begin
                r_ov <= 1'b1;
            end else if (pop) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cur <= i_desc;
        end
        if (adv) begin
            r_out <= rec;
        end
    end

endmodule
